// ===== hw/rtl/spot_light_radiance_defines.svh =====
// Assertion macros for the spotlight radiance pipeline.
`ifndef SPOT_LIGHT_RADIANCE_DEFINES_SVH
`define SPOT_LIGHT_RADIANCE_DEFINES_SVH

// Check a property in the same cycle as its trigger.
`define SLR_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("spot_light_radiance: check failed");

// Check a property at a delay after its trigger, with the delay given by argument n.
`define SLR_ASSERT_AFTER(lbl, cond, n, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (prop)) \
    else $error("spot_light_radiance: delayed check failed");

`endif

// ===== hw/rtl/spl_pkg.sv =====
// Shared types and constants of the spotlight radiance block.
package spl_pkg;

  typedef enum logic [2:0] {
    REG_LIGHT_POSITION  = 3'd0,
    REG_SPOT_DIRECTION  = 3'd1,
    REG_ATTEN_CONSTANT  = 3'd2,
    REG_ATTEN_LINEAR    = 3'd3,
    REG_ATTEN_QUADRATIC = 3'd4,
    REG_COS_INNER       = 3'd5,
    REG_COS_OUTER       = 3'd6,
    REG_INTENSITY_RGB   = 3'd7
  } cfg_reg_t;

  localparam int CFG_W = 60;

  // 1e-5 in units of 2^-28
  localparam logic [59:0] ATTEN_FLOOR = 60'd2684;
  localparam logic [8:0]  PDF_ONE     = 9'd256;
  localparam logic [16:0] K2_ONE      = 17'd65536;
  localparam logic [15:0] RAD_MAX     = 16'hFFFF;

  // Pipeline section lengths
  localparam int SQ_N = 29;  // square root steps
  localparam int CD_N = 17;  // cosine divide steps
  localparam int CN_N = 16;  // cone divide steps
  localparam int CH_N = 17;  // saturate check plus channel divide steps

endpackage

// ===== hw/rtl/spot_light_radiance.sv =====
// Spotlight radiance: fully pipelined distance and cone falloff for one point per clock.
// Takes one shaded point per clock (start is taken whenever busy is low, and busy
// stays low) and returns its radiance as a one-cycle done strobe; results cannot
// be held off, so the receiver must take every strobe.
// The pipeline is a chain of bit-per-stage units: a 29-step square root,
// a 17-step cosine divider, a 16-step cone divider and a 16-step channel divider
// with its saturation check, plus input, product, sum and output registers.
// Configuration writes take effect at once and must only happen while no point
// is in flight.
module spot_light_radiance
  import spl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  input  logic signed [19:0]  point_x,
  input  logic signed [19:0]  point_y,
  input  logic signed [19:0]  point_z,
  output logic [15:0]         radiance_r,
  output logic [15:0]         radiance_g,
  output logic [15:0]         radiance_b,
  output logic signed [19:0]  source_x,
  output logic signed [19:0]  source_y,
  output logic signed [19:0]  source_z,
  output logic [8:0]          sample_pdf
);

  `include "spot_light_radiance_defines.svh"

  localparam int LAT = 3 + (SQ_N + 1) + (CD_N + 1) + (CN_N + 1) + (CH_N + 1) + 1;

  // ---------------- configuration registers ----------------
  logic [59:0] light_position;
  logic [47:0] spot_direction;
  logic [15:0] atten_constant;
  logic [15:0] atten_linear;
  logic [15:0] atten_quadratic;
  logic [15:0] cos_inner;
  logic [15:0] cos_outer;
  logic [47:0] intensity_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_position  <= '0;
      spot_direction  <= '0;
      atten_constant  <= 16'd256;
      atten_linear    <= '0;
      atten_quadratic <= '0;
      cos_inner       <= 16'd16384;
      cos_outer       <= '0;
      intensity_rgb   <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_LIGHT_POSITION:  light_position  <= wr_data[59:0];
        REG_SPOT_DIRECTION:  spot_direction  <= wr_data[47:0];
        REG_ATTEN_CONSTANT:  atten_constant  <= wr_data[15:0];
        REG_ATTEN_LINEAR:    atten_linear    <= wr_data[15:0];
        REG_ATTEN_QUADRATIC: atten_quadratic <= wr_data[15:0];
        REG_COS_INNER:       cos_inner       <= wr_data[15:0];
        REG_COS_OUTER:       cos_outer       <= wr_data[15:0];
        REG_INTENSITY_RGB:   intensity_rgb   <= wr_data[47:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage A: offset to the light ----------------
  logic               a_v;
  logic signed [20:0] a_e [0:2];
  logic signed [19:0] pt  [0:2];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= start;
  end

  for (genvar i = 0; i < 3; i++) begin : g_a
    always_ff @(posedge clk) begin
      a_e[i] <= 21'($signed(light_position[20*i +: 20])) - 21'(pt[i]);
    end
  end

  // ---------------- stage B: squares and direction products ----------------
  logic               b_v;
  logic [41:0]        b_sq [0:2];
  logic signed [36:0] b_pd [0:2];

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else     b_v <= a_v;
  end

  for (genvar i = 0; i < 3; i++) begin : g_b
    logic [20:0] e_mag;
    assign e_mag = a_e[i][20] ? 21'(-a_e[i]) : 21'(a_e[i]);
    always_ff @(posedge clk) begin
      b_sq[i] <= e_mag * e_mag;
      b_pd[i] <= a_e[i] * $signed(spot_direction[16*i +: 16]);
    end
  end

  // ---------------- stage C: squared distance and dot product ----------------
  logic               c_v;
  logic [41:0]        c_r2;
  logic signed [38:0] c_dot;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else     c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    c_r2  <= b_sq[0] + b_sq[1] + b_sq[2];
    c_dot <= 39'(b_pd[0]) + 39'(b_pd[1]) + 39'(b_pd[2]);
  end

  // ---------------- square root, one result bit per stage ----------------
  logic               sq_v    [0:SQ_N];
  logic [57:0]        sq_x    [0:SQ_N-1];
  logic [31:0]        sq_rem  [0:SQ_N];
  logic [28:0]        sq_root [0:SQ_N];
  logic signed [38:0] sq_dot  [0:SQ_N];
  logic [57:0]        sq_qr2  [0:SQ_N];
  logic               sq_zero [0:SQ_N];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= c_v;
  end

  always_ff @(posedge clk) begin
    sq_x[0]    <= {c_r2, 16'b0};
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_dot[0]  <= c_dot;
    sq_qr2[0]  <= atten_quadratic * c_r2;
    sq_zero[0] <= (c_r2 == '0);
  end

  for (genvar i = 1; i <= SQ_N; i++) begin : g_sq
    logic [31:0] rem_in;
    logic [31:0] trial;
    logic        take;
    assign rem_in = {sq_rem[i-1][29:0], sq_x[i-1][2*(SQ_N-i)+1 -: 2]};
    assign trial  = {1'b0, sq_root[i-1], 2'b01};
    assign take   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) sq_v[i] <= 1'b0;
      else     sq_v[i] <= sq_v[i-1];
    end

    always_ff @(posedge clk) begin
      sq_rem[i]  <= take ? rem_in - trial : rem_in;
      sq_root[i] <= {sq_root[i-1][27:0], take};
      sq_dot[i]  <= sq_dot[i-1];
      sq_qr2[i]  <= sq_qr2[i-1];
      sq_zero[i] <= sq_zero[i-1];
    end

    if (i < SQ_N) begin : g_x
      always_ff @(posedge clk) begin
        sq_x[i] <= sq_x[i-1];
      end
    end
  end

  // ---------------- cosine divide: |dot| * 256 / R ----------------
  logic        cd_v    [0:CD_N];
  logic [28:0] cd_dv   [0:CD_N];
  logic [28:0] cd_rem  [0:CD_N];
  logic [16:0] cd_nlo  [0:CD_N];
  logic [16:0] cd_q    [0:CD_N];
  logic        cd_neg  [0:CD_N];
  logic        cd_zero [0:CD_N];
  logic [59:0] cd_den  [1:CD_N];
  logic [44:0] cd_lr;
  logic [57:0] cd_qr2;
  logic [38:0] dot_mag;
  logic [46:0] dot_num;

  assign dot_mag = sq_dot[SQ_N][38] ? 39'(-sq_dot[SQ_N]) : 39'(sq_dot[SQ_N]);
  assign dot_num = {dot_mag, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) cd_v[0] <= 1'b0;
    else     cd_v[0] <= sq_v[SQ_N];
  end

  always_ff @(posedge clk) begin
    cd_dv[0]   <= sq_root[SQ_N];
    cd_rem[0]  <= dot_num[45:17];
    cd_nlo[0]  <= dot_num[16:0];
    cd_q[0]    <= '0;
    cd_neg[0]  <= sq_dot[SQ_N][38];
    cd_zero[0] <= sq_zero[SQ_N];
    cd_lr      <= atten_linear * sq_root[SQ_N];
    cd_qr2     <= sq_qr2[SQ_N];
  end

  for (genvar i = 1; i <= CD_N; i++) begin : g_cd
    logic [29:0] rem_in;
    logic        take;
    assign rem_in = {cd_rem[i-1], cd_nlo[i-1][CD_N-i]};
    assign take   = (rem_in >= {1'b0, cd_dv[i-1]});

    always_ff @(posedge clk) begin
      if (rst) cd_v[i] <= 1'b0;
      else     cd_v[i] <= cd_v[i-1];
    end

    always_ff @(posedge clk) begin
      cd_dv[i]   <= cd_dv[i-1];
      cd_rem[i]  <= take ? 29'(rem_in - {1'b0, cd_dv[i-1]}) : rem_in[28:0];
      cd_nlo[i]  <= cd_nlo[i-1];
      cd_q[i]    <= {cd_q[i-1][15:0], take};
      cd_neg[i]  <= cd_neg[i-1];
      cd_zero[i] <= cd_zero[i-1];
    end

    if (i == 1) begin : g_den
      logic [59:0] den_sum;
      assign den_sum = 60'({atten_constant, 20'b0}) + 60'({cd_lr, 2'b0}) + 60'(cd_qr2);
      always_ff @(posedge clk) begin
        cd_den[i] <= (den_sum < ATTEN_FLOOR) ? ATTEN_FLOOR : den_sum;
      end
    end else begin : g_den_hold
      always_ff @(posedge clk) begin
        cd_den[i] <= cd_den[i-1];
      end
    end
  end

  // ---------------- cone factor setup and divide ----------------
  logic               cn_v     [0:CN_N];
  logic [15:0]        cn_dv    [0:CN_N];
  logic [15:0]        cn_rem   [0:CN_N];
  logic [15:0]        cn_q     [0:CN_N];
  logic               cn_fixed [0:CN_N];
  logic [16:0]        cn_fk2   [0:CN_N];
  logic [59:0]        cn_den   [0:CN_N];

  logic signed [17:0] cos_val;
  logic signed [18:0] cone_num;
  logic signed [16:0] cone_den;
  logic signed [18:0] num_f;
  logic signed [16:0] den_f;
  logic               fixed_c;
  logic [16:0]        fk2_c;

  always_comb begin
    if (cd_zero[CD_N])     cos_val = '0;
    else if (cd_neg[CD_N]) cos_val = -$signed({1'b0, cd_q[CD_N]});
    else                   cos_val = $signed({1'b0, cd_q[CD_N]});
    cone_num = 19'(cos_val) - 19'($signed(cos_outer));
    cone_den = 17'($signed(cos_inner)) - 17'($signed(cos_outer));
    num_f    = cone_den[16] ? -cone_num : cone_num;
    den_f    = cone_den[16] ? -cone_den : cone_den;
    fixed_c  = 1'b1;
    fk2_c    = '0;
    if (cone_den == '0) begin
      fk2_c = cone_num[18] ? 17'd0 : K2_ONE;
    end else if (num_f <= 0) begin
      fk2_c = '0;
    end else if (19'(den_f) <= num_f) begin
      fk2_c = K2_ONE;
    end else begin
      fixed_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cn_v[0] <= 1'b0;
    else     cn_v[0] <= cd_v[CD_N];
  end

  always_ff @(posedge clk) begin
    cn_dv[0]    <= den_f[15:0];
    cn_rem[0]   <= num_f[15:0];
    cn_q[0]     <= '0;
    cn_fixed[0] <= fixed_c;
    cn_fk2[0]   <= fk2_c;
    cn_den[0]   <= cd_den[CD_N];
  end

  for (genvar i = 1; i <= CN_N; i++) begin : g_cn
    logic [16:0] rem_in;
    logic        take;
    assign rem_in = {cn_rem[i-1], 1'b0};
    assign take   = (rem_in >= {1'b0, cn_dv[i-1]});

    always_ff @(posedge clk) begin
      if (rst) cn_v[i] <= 1'b0;
      else     cn_v[i] <= cn_v[i-1];
    end

    always_ff @(posedge clk) begin
      cn_dv[i]    <= cn_dv[i-1];
      cn_rem[i]   <= take ? 16'(rem_in - {1'b0, cn_dv[i-1]}) : rem_in[15:0];
      cn_q[i]     <= {cn_q[i-1][14:0], take};
      cn_fixed[i] <= cn_fixed[i-1];
      cn_fk2[i]   <= cn_fk2[i-1];
      cn_den[i]   <= cn_den[i-1];
    end
  end

  // ---------------- channel scale, saturate check and divide ----------------
  logic        ch_v   [0:CH_N];
  logic [59:0] ch_den [0:CH_N];
  logic [32:0] ch_p   [0:2];
  logic        ch_sat [0:2][1:CH_N];
  logic [3:0]  ch_nib [0:2][1:CH_N];
  logic [59:0] ch_rem [0:2][1:CH_N];
  logic [15:0] ch_q   [0:2][1:CH_N];
  logic [16:0] k2;

  assign k2 = cn_fixed[CN_N] ? cn_fk2[CN_N] : {1'b0, cn_q[CN_N]};

  always_ff @(posedge clk) begin
    if (rst) ch_v[0] <= 1'b0;
    else     ch_v[0] <= cn_v[CN_N];
  end

  always_ff @(posedge clk) begin
    ch_den[0] <= cn_den[CN_N];
  end

  for (genvar i = 1; i <= CH_N; i++) begin : g_chv
    always_ff @(posedge clk) begin
      if (rst) ch_v[i] <= 1'b0;
      else     ch_v[i] <= ch_v[i-1];
    end
    always_ff @(posedge clk) begin
      ch_den[i] <= ch_den[i-1];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    always_ff @(posedge clk) begin
      ch_p[c] <= intensity_rgb[16*c +: 16] * k2;
    end

    // saturate when (p << 12) / den would reach 2^16
    always_ff @(posedge clk) begin
      ch_sat[c][1] <= ({31'b0, ch_p[c]} >= {ch_den[0], 4'b0});
      ch_nib[c][1] <= ch_p[c][3:0];
      ch_rem[c][1] <= 60'(ch_p[c][32:4]);
      ch_q[c][1]   <= '0;
    end

    for (genvar i = 2; i <= CH_N; i++) begin : g_step
      logic        bit_in;
      logic [60:0] rem_in;
      logic        take;
      if (CH_N - i >= 12) begin : g_nib
        assign bit_in = ch_nib[c][i-1][CH_N - i - 12];
      end else begin : g_zero
        assign bit_in = 1'b0;
      end
      assign rem_in = {ch_rem[c][i-1], bit_in};
      assign take   = (rem_in >= {1'b0, ch_den[i-1]});

      always_ff @(posedge clk) begin
        ch_sat[c][i] <= ch_sat[c][i-1];
        ch_nib[c][i] <= ch_nib[c][i-1];
        ch_rem[c][i] <= take ? 60'(rem_in - {1'b0, ch_den[i-1]}) : rem_in[59:0];
        ch_q[c][i]   <= {ch_q[c][i-1][14:0], take};
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ch_v[CH_N];
  end

  always_ff @(posedge clk) begin
    radiance_r <= ch_sat[0][CH_N] ? RAD_MAX : ch_q[0][CH_N];
    radiance_g <= ch_sat[1][CH_N] ? RAD_MAX : ch_q[1][CH_N];
    radiance_b <= ch_sat[2][CH_N] ? RAD_MAX : ch_q[2][CH_N];
    source_x   <= $signed(light_position[19:0]);
    source_y   <= $signed(light_position[39:20]);
    source_z   <= $signed(light_position[59:40]);
    sample_pdf <= PDF_ONE;
  end

  // ---------------- assertions ----------------
  `SLR_ASSERT_AFTER(a_transfer_latency, start && !busy, LAT, done)
  `SLR_ASSERT_AFTER(a_no_spurious_done, !(start && !busy), LAT, !done)
  `SLR_ASSERT_NOW(a_cos_rem_bound, cd_v[CD_N] && !cd_zero[CD_N], cd_rem[CD_N] < cd_dv[CD_N])

endmodule
